// ===== design/rti_pkg.sv =====
// Shared definitions for the ray/triangle intersection pipeline.
// Holds configuration register indexes and the divider sideband type.
// No dependencies.
package rti_pkg;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_ORIGIN_X = 3'd0;
  localparam cfg_idx_t CFG_ORIGIN_Y = 3'd1;
  localparam cfg_idx_t CFG_ORIGIN_Z = 3'd2;
  localparam cfg_idx_t CFG_DIR_X    = 3'd3;
  localparam cfg_idx_t CFG_DIR_Y    = 3'd4;
  localparam cfg_idx_t CFG_DIR_Z    = 3'd5;

  // Per-item flags that travel beside the three dividers.
  typedef struct packed {
    logic       vld;
    logic       detz;
    logic [2:0] neg;
  } sb_t;

endpackage

// ===== design/rti_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// The quotient saturates to all ones when it does not fit in QB bits.
// No package dependencies.
module rti_divider #(
  parameter int NW = 98,
  parameter int DW = 78,
  parameter int QB = 45
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB-1:0] quo_o
);

  logic [DW-1:0] rem_q [QB+1];
  logic [DW-1:0] den_q [QB+1];
  logic [QB-1:0] lo_q  [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic          ovf_q [QB+1];

  // The upper numerator bits must already be below the divisor, or the
  // quotient needs more than QB bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DW'(num_i[NW-1:QB]);
      ovf_q[0] <= DW'(num_i[NW-1:QB]) >= den_i;
      den_q[0] <= den_i;
      lo_q[0]  <= num_i[QB-1:0];
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem_q[k], lo_q[k][QB-1-k]};
      diff  = trial - {1'b0, den_q[k]};
      ge    = trial >= {1'b0, den_q[k]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_q[k+1] <= {quo_q[k][QB-2:0], ge};
        den_q[k+1] <= den_q[k];
        lo_q[k+1]  <= lo_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo_o = ovf_q[QB] ? '1 : quo_q[QB];

endmodule

// ===== design/ray_triangle_intersection.sv =====
// Fixed-point ray/triangle intersection pipeline (top level).
// Depends on rti_pkg and rti_divider.
//
// Usage: the ray origin and direction are written through the cfg_* port
// while no request is in flight. Each slave request carries one triangle in
// s_axis_tdata (nine signed coordinates, vertex0 x/y/z first, lowest bits
// first). Each master request returns one result: the hit flag in bit 0,
// then the intersection x, y and z, all zero on a miss.
// One triangle is accepted per cycle; that figure is set by the fully
// pipelined datapath, whose longest part is the three long dividers that
// each resolve one quotient bit per stage. The datapath advances as a whole;
// a skid register behind the output register holds one extra result, so the
// block keeps accepting while one result waits at the output and stops only
// once both are full. Nothing is lost or repeated across a stall.
// Reset clears all valid bits and loads the ray registers with origin zero
// and direction (0, 0, -1.0).
module ray_triangle_intersection import rti_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  cfg_idx_t                         cfg_addr_i,
  input  logic [COORD_WIDTH-1:0]           cfg_wdata_i,
  // Triangle stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex2_z, zero pad
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // hit, hit_x, hit_y, hit_z, zero pad
  output logic [((1+3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int W     = COORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int OUT_W = ((1 + 3 * W + 7) / 8) * 8;
  localparam int EW    = W + 1;          // edge and offset vectors
  localparam int LW    = 2 * W + 3;      // cross product components
  localparam int LOW   = W + 1;          // low slice of a cross component
  localparam int HI    = LW - LOW;       // high slice of a cross component
  localparam int PLW   = EW + LOW + 1;
  localparam int PHW   = EW + HI;
  localparam int DW    = 3 * W + 6;      // dot products
  localparam int NW    = DW + F;         // scaled numerator magnitude
  localparam int QB    = F + W + 1;      // quotient bits kept
  localparam int H     = (QB + 1) / 2;   // split of t for the point products
  localparam int PRW   = QB + W;
  localparam int MW    = PRW - F;
  localparam int SW    = MW + 2;

  localparam logic signed [W-1:0]  DIR_Z_RST = -(W'(1) << F);
  localparam logic [QB-1:0]        ONE_Q     = QB'(1) << F;
  localparam logic signed [SW-1:0] SAT_MAX   = SW'((SW'(1) << (W - 1)) - SW'(1));
  localparam logic signed [SW-1:0] SAT_MIN   = ~SAT_MAX;

  // Configuration registers.
  logic signed [W-1:0] org_q [3];
  logic signed [W-1:0] dir_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= '0;
      dir_q[1] <= '0;
      dir_q[2] <= DIR_Z_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_ORIGIN_X: org_q[0] <= cfg_wdata_i;
        CFG_ORIGIN_Y: org_q[1] <= cfg_wdata_i;
        CFG_ORIGIN_Z: org_q[2] <= cfg_wdata_i;
        CFG_DIR_X:    dir_q[0] <= cfg_wdata_i;
        CFG_DIR_Y:    dir_q[1] <= cfg_wdata_i;
        CFG_DIR_Z:    dir_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The whole datapath moves only while the skid register is free.
  logic skid_v_q;
  logic adv;
  assign adv           = !skid_v_q;
  assign s_axis_tready = adv;

  logic signed [W-1:0]  vtx [3][3];
  logic signed [EW-1:0] dir_e [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        vtx[j][i] = s_axis_tdata[(3 * j + i) * W +: W];
      end
    end
    for (int i = 0; i < 3; i++) begin
      dir_e[i] = EW'(dir_q[i]);
    end
  end

  // Stage valid bits.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic p1_v_q, p2_v_q, p3_v_q;
  sb_t  sb_q [QB+1];
  // Stage 7 quotient signs and zero-determinant flag.
  logic [2:0] neg7_q;
  logic       detz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      for (int k = 0; k <= QB; k++) begin
        sb_q[k] <= '0;
      end
    end else if (adv) begin
      v1_q   <= s_axis_tvalid;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      p1_v_q <= sb_q[QB].vld;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      sb_q[0] <= '{vld: v7_q, detz: detz_q, neg: neg7_q};
      for (int k = 0; k < QB; k++) begin
        sb_q[k+1] <= sb_q[k];
      end
    end
  end

  // Stage 1: edges and origin offset.
  logic signed [EW-1:0] e1_s1_q [3], e2_s1_q [3], s_s1_q [3];
  // Stage 2: cross product terms.
  logic signed [2*EW-1:0] hp_q [3][2], qp_q [3][2];
  logic signed [EW-1:0]   e1_s2_q [3], e2_s2_q [3], s_s2_q [3];
  // Stage 3: h = dir x e2, q = s x e1.
  logic signed [LW-1:0] h_q [3], q_q [3];
  logic signed [EW-1:0] e1_s3_q [3], e2_s3_q [3], s_s3_q [3];
  // Stage 4: split dot partial products for det, u, v and t.
  logic signed [EW-1:0]  da [4][3];
  logic signed [LW-1:0]  db [4][3];
  logic signed [PLW-1:0] pl_q [4][3];
  logic signed [PHW-1:0] ph_q [4][3];
  // Stage 5 and 6: recombined terms, then dot sums.
  logic signed [DW-1:0] pc_q [4][3];
  logic signed [DW-1:0] dot_q [4];
  // Stage 7: magnitudes.
  logic [DW-1:0] dm_q;
  logic [NW-1:0] nm_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      da[0][i] = e1_s3_q[i];
      db[0][i] = h_q[i];
      da[1][i] = s_s3_q[i];
      db[1][i] = h_q[i];
      da[2][i] = dir_e[i];
      db[2][i] = q_q[i];
      da[3][i] = e2_s3_q[i];
      db[3][i] = q_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1_s1_q[i] <= EW'(vtx[1][i]) - EW'(vtx[0][i]);
        e2_s1_q[i] <= EW'(vtx[2][i]) - EW'(vtx[0][i]);
        s_s1_q[i]  <= EW'(org_q[i]) - EW'(vtx[0][i]);
        e1_s2_q[i] <= e1_s1_q[i];
        e2_s2_q[i] <= e2_s1_q[i];
        s_s2_q[i]  <= s_s1_q[i];
        e1_s3_q[i] <= e1_s2_q[i];
        e2_s3_q[i] <= e2_s2_q[i];
        s_s3_q[i]  <= s_s2_q[i];
        h_q[i]     <= LW'(hp_q[i][0]) - LW'(hp_q[i][1]);
        q_q[i]     <= LW'(qp_q[i][0]) - LW'(qp_q[i][1]);
      end
      hp_q[0][0] <= dir_e[1] * e2_s1_q[2];
      hp_q[0][1] <= dir_e[2] * e2_s1_q[1];
      hp_q[1][0] <= dir_e[2] * e2_s1_q[0];
      hp_q[1][1] <= dir_e[0] * e2_s1_q[2];
      hp_q[2][0] <= dir_e[0] * e2_s1_q[1];
      hp_q[2][1] <= dir_e[1] * e2_s1_q[0];
      qp_q[0][0] <= s_s1_q[1] * e1_s1_q[2];
      qp_q[0][1] <= s_s1_q[2] * e1_s1_q[1];
      qp_q[1][0] <= s_s1_q[2] * e1_s1_q[0];
      qp_q[1][1] <= s_s1_q[0] * e1_s1_q[2];
      qp_q[2][0] <= s_s1_q[0] * e1_s1_q[1];
      qp_q[2][1] <= s_s1_q[1] * e1_s1_q[0];
      for (int d = 0; d < 4; d++) begin
        for (int i = 0; i < 3; i++) begin
          pl_q[d][i] <= da[d][i] * $signed({1'b0, db[d][i][LOW-1:0]});
          ph_q[d][i] <= da[d][i] * $signed(db[d][i][LW-1:LOW]);
          pc_q[d][i] <= (DW'(ph_q[d][i]) <<< LOW) + DW'(pl_q[d][i]);
        end
        dot_q[d] <= pc_q[d][0] + pc_q[d][1] + pc_q[d][2];
      end
      dm_q   <= dot_q[0][DW-1] ? DW'(-dot_q[0]) : DW'(dot_q[0]);
      detz_q <= dot_q[0] == '0;
      for (int n = 0; n < 3; n++) begin
        nm_q[n]   <= {(dot_q[n+1][DW-1] ? DW'(-dot_q[n+1]) : DW'(dot_q[n+1])),
                      {F{1'b0}}};
        neg7_q[n] <= dot_q[n+1][DW-1] ^ dot_q[0][DW-1];
      end
    end
  end

  // u, v and t quotients, truncated toward zero in sign and magnitude form.
  logic [QB-1:0] quo [3];
  for (genvar n = 0; n < 3; n++) begin : g_div
    rti_divider #(.NW(NW), .DW(DW), .QB(QB)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (nm_q[n]),
      .den_i (dm_q),
      .quo_o (quo[n])
    );
  end

  // Hit test. A zero magnitude is a true zero because overflow saturates.
  logic u_ok, v_ok, sum_ok, t_ok, hit_d;
  logic [QB:0] uv_sum;
  always_comb begin
    u_ok   = (quo[0] == '0) || (!sb_q[QB].neg[0] && quo[0] <= ONE_Q);
    v_ok   = (quo[1] == '0) || (!sb_q[QB].neg[1] && quo[1] <= ONE_Q);
    uv_sum = {1'b0, quo[0]} + {1'b0, quo[1]};
    sum_ok = uv_sum <= {1'b0, ONE_Q};
    t_ok   = !sb_q[QB].neg[2] && quo[2] != '0;
    hit_d  = !sb_q[QB].detz && u_ok && v_ok && sum_ok && t_ok;
  end

  logic [W-1:0] dabs [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dabs[i] = dir_q[i][W-1] ? W'(-dir_q[i]) : W'(dir_q[i]);
    end
  end

  // Point stages: t*|dir| in two halves, recombine, scale, add and saturate.
  logic [H+W-1:0]    ml_q [3];
  logic [QB-H+W-1:0] mh_q [3];
  logic [2:0]        ps1_q, ps2_q;
  logic              hit1_q, hit2_q;
  logic [PRW-1:0]    full [3];
  logic [MW-1:0]     m_q [3];
  logic signed [SW-1:0] psum [3];
  logic signed [W-1:0]  pt_q [3];
  logic                 hit3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full[i] = (PRW'(mh_q[i]) << H) + PRW'(ml_q[i]);
      psum[i] = ps2_q[i] ? SW'(org_q[i]) - $signed({2'b00, m_q[i]})
                         : SW'(org_q[i]) + $signed({2'b00, m_q[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit1_q <= hit_d;
      hit2_q <= hit1_q;
      hit3_q <= hit2_q;
      for (int i = 0; i < 3; i++) begin
        ml_q[i]  <= (H+W)'(quo[2][H-1:0]) * (H+W)'(dabs[i]);
        mh_q[i]  <= (QB-H+W)'(quo[2][QB-1:H]) * (QB-H+W)'(dabs[i]);
        ps1_q[i] <= sb_q[QB].neg[2] ^ dir_q[i][W-1];
        ps2_q[i] <= ps1_q[i];
        m_q[i]   <= full[i][PRW-1:F];
        if (!hit2_q) begin
          pt_q[i] <= '0;
        end else if (psum[i] > SAT_MAX) begin
          pt_q[i] <= SAT_MAX[W-1:0];
        end else if (psum[i] < SAT_MIN) begin
          pt_q[i] <= SAT_MIN[W-1:0];
        end else begin
          pt_q[i] <= psum[i][W-1:0];
        end
      end
    end
  end

  // Output register and skid register.
  logic                out_v_q;
  logic                out_hit_q, skid_hit_q;
  logic signed [W-1:0] out_pt_q [3], skid_pt_q [3];
  logic                push;
  assign push = adv && p3_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_hit_q <= skid_hit_q;
        out_pt_q  <= skid_pt_q;
      end else begin
        out_hit_q <= hit3_q;
        out_pt_q  <= pt_q;
      end
    end else if (push) begin
      skid_hit_q <= hit3_q;
      skid_pt_q  <= pt_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_W'({out_pt_q[2], out_pt_q[1], out_pt_q[0], out_hit_q});

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && m_axis_tready) |=> !skid_v_q)
    else $error("skid register did not drain after the output was taken");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_hit_q) |-> (out_pt_q[0] == '0 && out_pt_q[1] == '0
                                 && out_pt_q[2] == '0))
    else $error("miss result carries a nonzero point");
`endif

endmodule
